// ===== rtl/fpq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants of the FIFO or max priority queue.
// ----------------------------------------------------------------------------
package fpq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CLR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_SRV_HEAD,
        S_SRV_RUN
    } t_state;

endpackage

// ===== rtl/fifo_or_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// fifo_or_max_priority_queue
// Bounded queue of signed values with FIFO or largest-first serving.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its one
// result appears for a single cycle with o_strobe; the receiver cannot stall
// it. The entries live in a circular buffer in one memory with a registered
// read. Clear, unused codes, refused enqueues, FIFO enqueues, enqueues into
// an empty queue and empty dequeues finish in the cycle they are taken. A
// FIFO dequeue reads the head entry and then finishes. A priority enqueue
// walks the entries backward, one memory read per cycle, past the entries
// smaller than the value. A priority dequeue reads the equal run one entry
// per cycle. The mode register is written only while the queue is empty.
module fifo_or_max_priority_queue #(
    parameter int DEPTH = fpq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic signed [31:0]          i_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    output logic                        o_strobe,
    output logic [1:0]                  o_status,
    output logic signed [31:0]          o_served_value,
    output logic [6:0]                  o_served_count,
    output logic [6:0]                  o_length
);
    import fpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_k, n_k;
    logic signed [31:0]     r_val, n_val;
    logic signed [31:0]     r_sv, n_sv;
    logic                   r_mode;

    logic                   r_strobe;
    logic [1:0]             r_status;
    logic signed [31:0]     r_out_sv;
    logic [CW-1:0]          r_out_cnt;
    logic [CW-1:0]          r_out_len;

    logic                   emit;
    t_status                e_status;
    logic signed [31:0]     e_sv;
    logic [CW-1:0]          e_cnt;
    logic [CW-1:0]          e_len;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VAL_W-1:0]       ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VAL_W-1:0]       ram_rdata;
    logic signed [31:0]     rd;
    logic [CW-1:0]          fin_k;
    logic                   fin;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(o);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    fpq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd          = $signed(ram_rdata);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_k       = r_k;
        n_val     = r_val;
        n_sv      = r_sv;
        ram_we    = 1'b0;
        ram_waddr = wrap(r_head, r_pos);
        ram_wdata = r_val;
        ram_raddr = r_head;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_sv      = '0;
        e_cnt     = '0;
        e_len     = r_count;
        fin       = 1'b0;
        fin_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val = i_value;
                    case (t_cmd'(i_command))
                        CMD_ENQ: begin
                            if (r_count == CW'(DEPTH)) begin
                                emit     = 1'b1;
                                e_status = ST_FULL;
                            end else if (!r_mode || r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = wrap(r_head, r_count);
                                ram_wdata = i_value;
                                n_count   = r_count + 1'b1;
                                emit      = 1'b1;
                                e_len     = r_count + 1'b1;
                            end else begin
                                n_pos     = r_count;
                                ram_raddr = wrap(r_head, r_count - 1'b1);
                                n_state   = S_INS;
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                ram_raddr = r_head;
                                n_k       = CW'(1);
                                n_state   = S_SRV_HEAD;
                            end
                        end
                        CMD_CLR: begin
                            emit    = 1'b1;
                            e_cnt   = r_count;
                            e_len   = '0;
                            n_count = '0;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                ram_we = 1'b1;
                if (rd < r_val) begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - 1'b1;
                    if (r_pos == CW'(1)) begin
                        n_state = S_INS_LAST;
                    end else begin
                        ram_raddr = wrap(r_head, r_pos - CW'(2));
                    end
                end else begin
                    n_count = r_count + 1'b1;
                    emit    = 1'b1;
                    e_len   = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INS_LAST: begin
                ram_we  = 1'b1;
                n_count = r_count + 1'b1;
                emit    = 1'b1;
                e_len   = r_count + 1'b1;
                n_state = S_IDLE;
            end
            S_SRV_HEAD: begin
                n_sv = rd;
                if (!r_mode || r_count == CW'(1)) begin
                    fin   = 1'b1;
                    fin_k = CW'(1);
                end else begin
                    ram_raddr = wrap(r_head, CW'(1));
                    n_state   = S_SRV_RUN;
                end
            end
            S_SRV_RUN: begin
                if (rd == r_sv) begin
                    n_k = r_k + 1'b1;
                    if (r_k + 1'b1 == r_count) begin
                        fin   = 1'b1;
                        fin_k = r_k + 1'b1;
                    end else begin
                        ram_raddr = wrap(r_head, r_k + 1'b1);
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_head  = wrap(r_head, fin_k);
            n_count = r_count - fin_k;
            emit    = 1'b1;
            e_sv    = n_sv;
            e_cnt   = fin_k;
            e_len   = r_count - fin_k;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_mode   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= emit;
            if (i_cfg_valid && o_cfg_ready && r_count == '0) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_k   <= n_k;
        r_val <= n_val;
        r_sv  <= n_sv;
        if (emit) begin
            r_status  <= e_status;
            r_out_sv  <= e_sv;
            r_out_cnt <= e_cnt;
            r_out_len <= e_len;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_served_value = r_out_sv;
    assign o_served_count = 7'(r_out_cnt);
    assign o_length       = 7'(r_out_len);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_FULL |-> o_length == 7'(DEPTH))
        else $error("refused enqueue with queue not full");
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_EMPTY |-> o_length == 7'd0 && o_served_count == 7'd0)
        else $error("empty dequeue reports entries");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == CMD_DEQ && r_count != '0 |=> busy)
        else $error("dequeue of a filled queue did not read the store");
`endif

endmodule

// ===== rtl/fpq_ram.sv =====
// ----------------------------------------------------------------------------
// fpq_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpq_ram #(
    parameter int DEPTH = fpq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [fpq_pkg::VAL_W-1:0]   i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [fpq_pkg::VAL_W-1:0]   o_rdata
);
    import fpq_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO or max priority queue.
// ----------------------------------------------------------------------------
// Directed commands cover the value extremes in both modes and the empty,
// clear and unused-command cases in FIFO mode. Random phases with varied
// enqueue ratios then fill, drain and serve equal-value runs. A scoreboard
// predicts every result from its own copy of the queue and the mode.
// ----------------------------------------------------------------------------
module testbench;
    import fpq_pkg::*;

    localparam int          QUEUE_DEPTH = DEPTH_DEF;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]          status;
        logic signed [31:0]  value;
        logic [6:0]          count;
        logic [6:0]          length;
    } t_outcome;

    class queue_scoreboard;
        int               entries[$];
        bit               prio_mode;
        t_outcome         awaited[$];
        int               errors;

        function void set_mode(bit data);
            if (entries.size() == 0) prio_mode = data;
        endfunction

        function void note_command(logic [1:0] cmd, logic signed [31:0] val);
            t_outcome o;
            int       pos;
            o = '{ST_OK, 32'sd0, 7'd0, 7'd0};
            if (cmd == CMD_ENQ) begin
                if (entries.size() >= QUEUE_DEPTH) begin
                    o.status = ST_FULL;
                end else if (prio_mode) begin
                    pos = 0;
                    while (pos < entries.size() && entries[pos] >= val) pos++;
                    entries.insert(pos, val);
                end else begin
                    entries.push_back(val);
                end
            end else if (cmd == CMD_DEQ) begin
                if (entries.size() == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.value = entries[0];
                    pos = 1;
                    if (prio_mode)
                        while (pos < entries.size() && entries[pos] == entries[0]) pos++;
                    o.count = 7'(pos);
                    repeat (pos) void'(entries.pop_front());
                end
            end else if (cmd == CMD_CLR) begin
                o.count = 7'(entries.size());
                entries.delete();
            end
            o.length = 7'(entries.size());
            awaited.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (awaited.size() == 0) begin
                $display("%0t: result with none pending: status %0d value %0d",
                         $time, got.status, got.value);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t: served_value expected %0d actual %0d",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: served_count expected %0d actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: length expected %0d actual %0d",
                         $time, want.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_command = CMD_ENQ;
    logic signed [31:0] i_value = 32'sd0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic signed [31:0] o_served_value;
    logic [6:0]         o_served_count;
    logic [6:0]         o_length;

    queue_scoreboard    sb = new();
    bit                 steady;
    int                 cycles;

    fifo_or_max_priority_queue #(.DEPTH(QUEUE_DEPTH)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_served_value (o_served_value),
        .o_served_count (o_served_count),
        .o_length       (o_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_mode(i_cfg_data);
            if (start && !busy) sb.note_command(i_command, i_value);
            if (o_strobe)
                sb.check_result('{o_status, o_served_value, o_served_count, o_length});
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("fifo_or_max_priority_queue: mismatch");
            $finish;
        end
    end

    task automatic issue(logic [1:0] cmd, logic signed [31:0] val);
        while (!steady && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(bit data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50) return $signed($urandom_range(4)) - 2;
        if (r < 60) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    initial begin
        int enq_pct;
        int r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(1'b0);
        issue(CMD_DEQ, 32'sd0);
        issue(CMD_ENQ, 32'sh80000000);
        issue(CMD_ENQ, 32'sh7fffffff);
        issue(CMD_ENQ, -32'sd1);
        issue(CMD_ENQ, 32'sd0);
        issue(CMD_UNUSED, 32'sd9);
        issue(CMD_DEQ, 32'sd0);
        issue(CMD_DEQ, 32'sd0);
        issue(CMD_CLR, 32'sd0);
        write_mode(1'b1);
        issue(CMD_ENQ, 32'sd5);
        issue(CMD_ENQ, 32'sd5);
        issue(CMD_ENQ, -32'sd3);
        issue(CMD_ENQ, 32'sh7fffffff);
        issue(CMD_ENQ, 32'sd5);
        issue(CMD_ENQ, 32'sh80000000);
        write_mode(1'b0);
        issue(CMD_DEQ, 32'sd0);
        issue(CMD_DEQ, 32'sd0);
        issue(CMD_DEQ, 32'sd0);
        issue(CMD_CLR, 32'sd0);
        issue(CMD_DEQ, 32'sd0);

        for (int phase = 0; phase < 8; phase++) begin
            if ($urandom_range(3) != 0) issue(CMD_CLR, 32'sd0);
            write_mode(phase[0] ^ (phase > 5));
            steady  = (phase == 5);
            enq_pct = (phase == 3 || phase == 6) ? 92 : $urandom_range(40, 70);
            for (int n = 0; n < 80; n++) begin
                r = $urandom_range(99);
                if (r < enq_pct)  issue(CMD_ENQ, pick_value());
                else if (r < 97)  issue(CMD_DEQ, $urandom);
                else if (r < 99)  issue(CMD_CLR, $urandom);
                else              issue(CMD_UNUSED, $urandom);
            end
        end
        steady = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("fifo_or_max_priority_queue: match");
        end else begin
            $display("fifo_or_max_priority_queue: mismatch");
        end
        $finish;
    end
endmodule
